[hdl/tneg_pkg.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator package
// Shared constants, option code table and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tneg_pkg;

  localparam int CODE_COUNT = 4;
  localparam int NSIDE = 2 * CODE_COUNT;
  localparam int SIDX_W = $clog2(NSIDE);
  localparam int OIDX_W = $clog2(CODE_COUNT);
  localparam int KNOWN_OPTIONS_DEFAULT = 4;

  localparam logic [2:0] REQ_MUSTNOT = 3'd0;
  localparam logic [2:0] REQ_BETTERNOT = 3'd1;
  localparam logic [2:0] REQ_BETTER = 3'd3;
  localparam logic [2:0] REQ_MUST = 3'd4;

  localparam logic [1:0] CMD_WILL = 2'd0;
  localparam logic [1:0] CMD_WONT = 2'd1;
  localparam logic [1:0] CMD_DO = 2'd2;
  localparam logic [1:0] CMD_DONT = 2'd3;

  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_PASS = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  localparam logic [7:0] OPT_CODE [CODE_COUNT] = '{8'd0, 8'd1, 8'd3, 8'd24};
  localparam logic [2:0] REQ_RESET [NSIDE] =
    '{3'd3, 3'd3, 3'd0, 3'd3, 3'd3, 3'd4, 3'd2, 3'd0};

  typedef struct packed {
    logic load;
    logic exec;
    logic walk_step;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       mask_empty;
    logic       walk_end;
  } dp_status_t;

endpackage

`default_nettype wire

[hdl/tneg_ctrl.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator controller
// Sequences item acceptance, single-step execution and the request walk.
// ----------------------------------------------------------------------------
`default_nettype none

module tneg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  output tneg_pkg::dp_cmd_t         dp_cmd,
  input  wire tneg_pkg::dp_status_t dp_status
);
  import tneg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t state;

  always_comb begin
    dp_cmd.load = (state == S_IDLE) && start;
    dp_cmd.exec = (state == S_EXEC);
    dp_cmd.walk_step = (state == S_WALK);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_EXEC;
            busy <= 1'b1;
          end
        end
        S_EXEC: begin
          if (dp_status.kind == KIND_PASS && !dp_status.mask_empty) begin
            state <= S_WALK;
          end else begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        S_WALK: begin
          if (dp_status.walk_end) begin
            state <= S_IDLE;
            busy <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
          busy <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/tneg_dp.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator datapath
// Requirement registers, per-side enabled and pending bits, reply logic and
// the registered result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tneg_dp #(
  parameter int KNOWN_OPTIONS = tneg_pkg::KNOWN_OPTIONS_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tneg_pkg::dp_cmd_t                 dp_cmd,
  output tneg_pkg::dp_status_t                   dp_status,
  input  wire logic [1:0]                        kind,
  input  wire logic [1:0]                        cmd,
  input  wire logic [7:0]                        opt,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [tneg_pkg::SIDX_W-1:0]       cfg_index,
  input  wire logic [2:0]                        cfg_data,
  output logic                                   strobe,
  output logic                                   send_valid,
  output logic [1:0]                             send_cmd,
  output logic [7:0]                             send_opt,
  output logic                                   refused,
  output logic                                   binary_send,
  output logic                                   binary_receive,
  output logic                                   sga_enabled,
  output logic                                   last
);
  import tneg_pkg::*;

  logic [2:0]        reqs [NSIDE];
  logic [NSIDE-1:0]  en;
  logic [NSIDE-1:0]  pend;
  logic [1:0]        item_kind;
  logic [1:0]        item_cmd;
  logic [7:0]        item_opt;
  logic [SIDX_W-1:0] sidx;

  logic [NSIDE-1:0]  en_next;
  logic [NSIDE-1:0]  pend_next;
  logic [NSIDE-1:0]  mask;
  logic [NSIDE-1:0]  rest;
  logic              walk_end;
  logic              hit;
  logic [OIDX_W-1:0] idx;
  logic [SIDX_W-1:0] cs;
  logic [2:0]        req;
  logic              want;
  logic              pending;
  logic              enabled;
  logic [2:0]        must_neg;
  logic [2:0]        better_neg;
  logic [1:0]        pass_cmd;
  logic              emit;
  logic              r_valid;
  logic [1:0]        r_cmd;
  logic [7:0]        r_opt;
  logic              r_ref;
  logic              r_last;

  assign cfg_ready = 1'b1;

  always_comb begin
    mask = '0;
    for (int i = 0; i < CODE_COUNT; i++) begin
      for (int sd = 0; sd < 2; sd++) begin
        if (i < KNOWN_OPTIONS) begin
          if (((reqs[2*i+sd] == REQ_MUSTNOT) || (reqs[2*i+sd] == REQ_BETTERNOT))
              && en[2*i+sd]) begin
            mask[2*i+sd] = 1'b1;
          end
          if (((reqs[2*i+sd] == REQ_BETTER) || (reqs[2*i+sd] == REQ_MUST))
              && !en[2*i+sd]) begin
            mask[2*i+sd] = 1'b1;
          end
        end
      end
    end
    rest = (mask >> sidx) >> 1;
    walk_end = (rest == '0);

    if (en[sidx]) begin
      pass_cmd = sidx[0] ? CMD_DONT : CMD_WONT;
    end else begin
      pass_cmd = sidx[0] ? CMD_DO : CMD_WILL;
    end

    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < CODE_COUNT; i++) begin
      if (i < KNOWN_OPTIONS && OPT_CODE[i] == item_opt) begin
        hit = 1'b1;
        idx = OIDX_W'(i);
      end
    end
    cs = {idx, ~item_cmd[1]};
    req = reqs[cs];
    want = ~item_cmd[0];
    pending = pend[cs];
    enabled = en[cs];
    must_neg = want ? REQ_MUSTNOT : REQ_MUST;
    better_neg = want ? REQ_BETTERNOT : REQ_BETTER;

    en_next = en;
    pend_next = pend;
    emit = 1'b0;
    r_valid = 1'b0;
    r_cmd = CMD_WILL;
    r_opt = '0;
    r_ref = 1'b0;
    r_last = 1'b0;

    if (dp_cmd.exec) begin
      case (item_kind)
        KIND_CMD: begin
          emit = 1'b1;
          r_last = 1'b1;
          if (!hit) begin
            r_valid = 1'b1;
            r_cmd = item_cmd[1] ? CMD_WONT : CMD_DONT;
            r_opt = item_opt;
          end else if (req == must_neg || req == better_neg) begin
            if (pending) begin
              pend_next[cs] = 1'b0;
              if (req == must_neg) begin
                r_ref = 1'b1;
              end else if (enabled != want) begin
                en_next[cs] = want;
                r_valid = 1'b1;
                r_cmd = item_cmd ^ 2'b10;
                r_opt = item_opt;
              end
            end else begin
              r_valid = 1'b1;
              r_cmd = item_cmd ^ 2'b11;
              r_opt = item_opt;
            end
          end else begin
            en_next[cs] = want;
            if (pending) begin
              pend_next[cs] = 1'b0;
            end else begin
              r_valid = 1'b1;
              r_cmd = item_cmd ^ 2'b10;
              r_opt = item_opt;
            end
          end
        end
        KIND_PASS: begin
          if (mask == '0) begin
            emit = 1'b1;
            r_last = 1'b1;
          end
        end
        KIND_RESET: begin
          en_next = '0;
          pend_next = '0;
          emit = 1'b1;
          r_last = 1'b1;
        end
        default: begin
          emit = 1'b1;
          r_last = 1'b1;
        end
      endcase
    end

    if (dp_cmd.walk_step && mask[sidx]) begin
      emit = 1'b1;
      r_valid = 1'b1;
      r_cmd = pass_cmd;
      r_opt = OPT_CODE[sidx[SIDX_W-1:1]];
      r_last = walk_end;
      pend_next[sidx] = 1'b1;
    end

    dp_status.kind = item_kind;
    dp_status.mask_empty = (mask == '0);
    dp_status.walk_end = walk_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSIDE; i++) begin
        reqs[i] <= REQ_RESET[i];
      end
      en <= '0;
      pend <= '0;
      strobe <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        reqs[cfg_index] <= cfg_data;
      end
      en <= en_next;
      pend <= pend_next;
      strobe <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      item_kind <= kind;
      item_cmd <= cmd;
      item_opt <= opt;
      sidx <= '0;
    end else if (dp_cmd.walk_step) begin
      sidx <= sidx + 1'b1;
    end
    if (emit) begin
      send_valid <= r_valid;
      send_cmd <= r_cmd;
      send_opt <= r_opt;
      refused <= r_ref;
      binary_send <= en_next[0];
      binary_receive <= en_next[1];
      sga_enabled <= en_next[5];
      last <= r_last;
    end
  end

endmodule

`default_nettype wire

[hdl/telnet_option_negotiator.sv]
// ----------------------------------------------------------------------------
// Telnet option negotiator
// Answers received WILL/WONT/DO/DONT commands for binary, echo,
// suppress-go-ahead and terminal type, and issues option requests.
// ----------------------------------------------------------------------------
// An item is taken on kind, cmd and opt at a clock edge with start high and
// busy low. Kind selects a received command, a send-requests pass or a
// session reset. Each result beat appears for one cycle with strobe high;
// last marks the final beat of an item. The receiver cannot stall.
// A received command, a session reset or a pass that sends nothing gives
// one beat from the execute state through the result stage, and busy is low
// again in the cycle that beat is shown, so the next item can be taken then.
// A send-requests pass walks the eight option sides one per cycle through
// the request counter, from the first side up to the last side that needs
// a request, giving one beat per request.
// Requirement registers are written on the cfg channel, which is always ready;
// the user must do so only while the block is idle, which it does not enforce.
// Reset clears all enabled and pending bits and loads the default
// requirements; no beat is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module telnet_option_negotiator #(
  parameter int KNOWN_OPTIONS = tneg_pkg::KNOWN_OPTIONS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  kind,
  input  wire logic [1:0]                  cmd,
  input  wire logic [7:0]                  opt,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [tneg_pkg::SIDX_W-1:0] cfg_index,
  input  wire logic [2:0]                  cfg_data,
  output logic                             strobe,
  output logic                             send_valid,
  output logic [1:0]                       send_cmd,
  output logic [7:0]                       send_opt,
  output logic                             refused,
  output logic                             binary_send,
  output logic                             binary_receive,
  output logic                             sga_enabled,
  output logic                             last
);
  import tneg_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  tneg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .dp_cmd    (dp_cmd),
    .dp_status (dp_status)
  );

  tneg_dp #(
    .KNOWN_OPTIONS (KNOWN_OPTIONS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .dp_status      (dp_status),
    .kind           (kind),
    .cmd            (cmd),
    .opt            (opt),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .strobe         (strobe),
    .send_valid     (send_valid),
    .send_cmd       (send_cmd),
    .send_opt       (send_opt),
    .refused        (refused),
    .binary_send    (binary_send),
    .binary_receive (binary_receive),
    .sga_enabled    (sga_enabled),
    .last           (last)
  );

endmodule

`default_nettype wire
